// ----- sv/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// cond holds -> prop holds in the same cycle
`define ASSERT_IMPLY(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("scheduler assertion failed");
// cond holds -> prop holds in the next cycle
`define ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("scheduler assertion failed");
`else
`define ASSERT_IMPLY(name, cond, prop)
`define ASSERT_NEXT(name, cond, prop)
`endif

`endif

// ----- sv/rrts_pkg.sv -----
// Types, codes and helpers of the round-robin task scheduler.
package rrts_pkg;

    localparam int MAX_TASKS_DEF  = 32;
    localparam int SLICE_BITS_DEF = 16;

    // command codes
    localparam logic [2:0] CMD_TICK        = 3'd0;
    localparam logic [2:0] CMD_ADD         = 3'd1;
    localparam logic [2:0] CMD_REMOVE      = 3'd2;
    localparam logic [2:0] CMD_YIELD       = 3'd3;
    localparam logic [2:0] CMD_SLEEP_FOR   = 3'd4;
    localparam logic [2:0] CMD_SLEEP_UNTIL = 3'd5;
    localparam logic [2:0] CMD_SET_STATE   = 3'd6;
    localparam logic [2:0] CMD_WAKE        = 3'd7;

    // task state codes
    localparam logic [2:0] ST_UNUSED        = 3'd0;
    localparam logic [2:0] ST_READY         = 3'd1;
    localparam logic [2:0] ST_RUNNING       = 3'd2;
    localparam logic [2:0] ST_SLEEPING      = 3'd3;
    localparam logic [2:0] ST_BLOCKED       = 3'd4;
    localparam logic [2:0] ST_BLOCKED_IO    = 3'd5;
    localparam logic [2:0] ST_WAITING_CHILD = 3'd6;
    localparam logic [2:0] ST_ZOMBIE        = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  task_id;
        logic        target_current;
        logic [63:0] tick_value;
        logic [63:0] time_amount;
        logic [15:0] slice_ticks;
        logic        has_entry;
        logic [2:0]  new_state;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  assigned_id;
        logic [4:0]  current_task;
        logic        reschedule_pending;
        logic [5:0]  live_count;
        logic [31:0] switch_total;
        logic [31:0] yield_total;
        logic [31:0] wakeup_total;
    } rsp_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_WAKE,
        OP_CHARGE,
        OP_SEARCH_INIT,
        OP_SEARCH,
        OP_RELOAD,
        OP_SW_OUT,
        OP_SW_IN,
        OP_ADD_STEP,
        OP_ADD_WRITE,
        OP_SINGLE,
        OP_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       wake_last;
        logic       add_done;
        logic       search_done;
        logic       resched;
        logic       switch_needed;
    } stat_t;

    function automatic logic is_runnable(input logic [2:0] s);
        return (s == ST_READY) || (s == ST_RUNNING);
    endfunction

endpackage

// ----- sv/round_robin_task_scheduler_unit.sv -----
// Top level of the round-robin time-slice task scheduler.
// One command transaction is taken at a time and answered by exactly one result transaction.
// The task table has a single access per cycle, and that port sets the timing. Remove,
// yield, sleep, set_state and wake each make one table access; add scans the N slots in use
// for the lowest free slot; a tick scans all N slots for due sleepers, then on a reschedule
// runs a round-robin search of up to N slots and a switch made of a switch-out and a
// switch-in step. A finished result sits in an output register, so a stalled result delays
// only the next transaction.
`include "assert_macros.svh"

module round_robin_task_scheduler_unit
#(
    parameter int MAX_TASKS  = rrts_pkg::MAX_TASKS_DEF,
    parameter int SLICE_BITS = rrts_pkg::SLICE_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rrts_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rrts_pkg::rsp_t rsp
);

    rrts_pkg::ctl_t  ctl;
    rrts_pkg::stat_t stat;

    rrts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl),
        .stat      (stat)
    );

    rrts_dp
    #(
        .MAX_TASKS  (MAX_TASKS),
        .SLICE_BITS (SLICE_BITS)
    )
    u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctl   (ctl),
        .stat  (stat),
        .rsp   (rsp)
    );

    // one transaction in flight: busy right after acceptance
    `ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
    // a stalled result stays put
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `ASSERT_IMPLY(a_current_bound, rsp_valid, 6'(rsp.current_task) < 6'(MAX_TASKS))

endmodule

// ----- sv/rrts_ctrl.sv -----
// Controller state machine of the task scheduler.
module rrts_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rrts_pkg::ctl_t ctl,
    input  rrts_pkg::stat_t stat
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_DISPATCH  = 13'b0000000000010,
        S_WAKE      = 13'b0000000000100,
        S_CHARGE    = 13'b0000000001000,
        S_CHECK     = 13'b0000000010000,
        S_SEARCH    = 13'b0000000100000,
        S_RELOAD    = 13'b0000001000000,
        S_SW_OUT    = 13'b0000010000000,
        S_SW_IN     = 13'b0000100000000,
        S_ADD_SCAN  = 13'b0001000000000,
        S_ADD_WRITE = 13'b0010000000000,
        S_SINGLE    = 13'b0100000000000,
        S_RESULT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   load;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign load      = (state_reg == S_RESULT) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = rrts_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.op     = rrts_pkg::OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.cmd == rrts_pkg::CMD_TICK)
                    state_next = S_WAKE;
                else if (stat.cmd == rrts_pkg::CMD_ADD)
                    state_next = S_ADD_SCAN;
                else
                    state_next = S_SINGLE;
            end
            S_WAKE:
            begin
                ctl.op = rrts_pkg::OP_WAKE;
                if (stat.wake_last)
                    state_next = S_CHARGE;
            end
            S_CHARGE:
            begin
                ctl.op     = rrts_pkg::OP_CHARGE;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ctl.op     = rrts_pkg::OP_SEARCH_INIT;
                state_next = stat.resched ? S_SEARCH : S_RESULT;
            end
            S_SEARCH:
            begin
                ctl.op = rrts_pkg::OP_SEARCH;
                if (stat.search_done)
                    state_next = S_RELOAD;
            end
            S_RELOAD:
            begin
                ctl.op     = rrts_pkg::OP_RELOAD;
                state_next = stat.switch_needed ? S_SW_OUT : S_RESULT;
            end
            S_SW_OUT:
            begin
                ctl.op     = rrts_pkg::OP_SW_OUT;
                state_next = S_SW_IN;
            end
            S_SW_IN:
            begin
                ctl.op     = rrts_pkg::OP_SW_IN;
                state_next = S_RESULT;
            end
            S_ADD_SCAN:
            begin
                ctl.op = rrts_pkg::OP_ADD_STEP;
                if (stat.add_done)
                    state_next = S_ADD_WRITE;
            end
            S_ADD_WRITE:
            begin
                ctl.op     = rrts_pkg::OP_ADD_WRITE;
                state_next = S_RESULT;
            end
            S_SINGLE:
            begin
                ctl.op     = rrts_pkg::OP_SINGLE;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (load)
                begin
                    ctl.op     = rrts_pkg::OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- sv/rrts_dp.sv -----
// Datapath of the task scheduler: task table, scan pointers, counters, result register.
module rrts_dp
#(
    parameter int MAX_TASKS  = rrts_pkg::MAX_TASKS_DEF,
    parameter int SLICE_BITS = rrts_pkg::SLICE_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  rrts_pkg::req_t  req,
    input  rrts_pkg::ctl_t  ctl,
    output rrts_pkg::stat_t stat,
    output rrts_pkg::rsp_t  rsp
);

    localparam int IW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int DEPTH = 2 ** IW;
    localparam logic [31:0] SMAX32 = (SLICE_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << SLICE_BITS) - 64'd1);

    typedef logic [IW-1:0]         idx_t;
    typedef logic [CW-1:0]         cnt_t;
    typedef logic [SLICE_BITS-1:0] slice_t;

    // task table, one access per cycle
    logic [2:0]  st_reg    [DEPTH];
    slice_t      slice_reg [DEPTH];
    slice_t      left_reg  [DEPTH];
    logic [63:0] wake_reg  [DEPTH];
    logic [DEPTH-1:0] ent_reg;

    rrts_pkg::req_t q_reg, q_next;
    rrts_pkg::rsp_t rsp_reg, rsp_next;

    idx_t        idx_reg, idx_next;
    cnt_t        cnt_reg, cnt_next;
    idx_t        pick_reg, pick_next;
    idx_t        slot_reg, slot_next;
    logic        found_reg, found_next;
    idx_t        run_reg, run_next;
    cnt_t        slots_reg, slots_next;
    logic        resched_reg, resched_next;
    // freeing a slot by set_state leaves the count alone, so it can pass the table size
    logic [31:0] live_reg, live_next;
    logic [31:0] sw_reg, sw_next;
    logic [31:0] yld_reg, yld_next;
    logic [31:0] wk_reg, wk_next;
    logic        ok_reg, ok_next;
    idx_t        asg_reg, asg_next;

    idx_t        addr;
    logic [2:0]  rd_st;
    slice_t      rd_slice;
    slice_t      rd_left;
    logic [63:0] rd_wake;
    logic        rd_ent;

    logic        wr_en;
    logic [2:0]  w_st;
    slice_t      w_slice;
    slice_t      w_left;
    logic [63:0] w_wake;
    logic        w_ent;

    logic        is_yield;
    logic        is_sleep;
    logic        use_cur;
    logic        in_range;
    idx_t        tgt;
    logic        tgt_zero;
    logic        used;
    logic        can_run;
    logic        add_hit;
    cnt_t        slots_m1;
    cnt_t        run_p1;
    cnt_t        idx_p1;
    logic [31:0] sl_ext;
    logic [31:0] sl_clamp;
    slice_t      dec_left;
    logic [2:0]  ns_eff;

    assign is_yield = (q_reg.cmd == rrts_pkg::CMD_YIELD) ||
                      ((q_reg.cmd == rrts_pkg::CMD_SLEEP_FOR) && (q_reg.time_amount == 64'd0));
    assign is_sleep = ((q_reg.cmd == rrts_pkg::CMD_SLEEP_FOR) && (q_reg.time_amount != 64'd0)) ||
                      (q_reg.cmd == rrts_pkg::CMD_SLEEP_UNTIL);
    assign use_cur  = q_reg.target_current && (is_yield || is_sleep);
    assign in_range = 6'(q_reg.task_id) < 6'(slots_reg);
    assign tgt      = use_cur ? run_reg : q_reg.task_id[IW-1:0];
    assign tgt_zero = use_cur ? (run_reg == '0) : (q_reg.task_id == 5'd0);

    assign slots_m1 = slots_reg - cnt_t'(1);
    assign run_p1   = cnt_t'(run_reg) + cnt_t'(1);
    assign idx_p1   = cnt_t'(idx_reg) + cnt_t'(1);

    always_comb
    begin
        case (ctl.op)
            rrts_pkg::OP_WAKE,
            rrts_pkg::OP_SEARCH,
            rrts_pkg::OP_ADD_STEP:  addr = idx_reg;
            rrts_pkg::OP_SW_IN:     addr = pick_reg;
            rrts_pkg::OP_ADD_WRITE: addr = found_reg ? slot_reg : slots_reg[IW-1:0];
            rrts_pkg::OP_SINGLE:    addr = tgt;
            default:                addr = run_reg;
        endcase
    end

    assign rd_st    = st_reg[addr];
    assign rd_slice = slice_reg[addr];
    assign rd_left  = left_reg[addr];
    assign rd_wake  = wake_reg[addr];
    assign rd_ent   = ent_reg[addr];

    assign used     = in_range && (rd_st != rrts_pkg::ST_UNUSED);
    assign can_run  = rd_ent && rrts_pkg::is_runnable(rd_st);
    assign add_hit  = (idx_reg != '0) && (cnt_t'(idx_reg) < slots_reg) &&
                      (rd_st == rrts_pkg::ST_UNUSED);
    assign dec_left = (rd_left != '0) ? rd_left - slice_t'(1) : rd_left;
    assign ns_eff   = ((q_reg.new_state == rrts_pkg::ST_RUNNING) && (tgt != run_reg)) ?
                      rrts_pkg::ST_READY : q_reg.new_state;

    // add: zero raised to one, large values saturate to the slice range
    assign sl_ext   = 32'(q_reg.slice_ticks);
    assign sl_clamp = (sl_ext == 32'd0) ? 32'd1 : ((sl_ext > SMAX32) ? SMAX32 : sl_ext);

    assign stat.cmd           = q_reg.cmd;
    assign stat.wake_last     = (cnt_t'(idx_reg) == slots_m1);
    assign stat.add_done      = add_hit || (cnt_t'(idx_reg) >= slots_m1);
    assign stat.search_done   = can_run || (cnt_reg == slots_reg);
    assign stat.resched       = resched_reg;
    assign stat.switch_needed = (pick_reg != run_reg);

    assign rsp = rsp_reg;

    always_comb
    begin
        q_next       = q_reg;
        rsp_next     = rsp_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        pick_next    = pick_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        run_next     = run_reg;
        slots_next   = slots_reg;
        resched_next = resched_reg;
        live_next    = live_reg;
        sw_next      = sw_reg;
        yld_next     = yld_reg;
        wk_next      = wk_reg;
        ok_next      = ok_reg;
        asg_next     = asg_reg;
        wr_en        = 1'b0;
        w_st         = rd_st;
        w_slice      = rd_slice;
        w_left       = rd_left;
        w_wake       = rd_wake;
        w_ent        = rd_ent;

        case (ctl.op)
            rrts_pkg::OP_LATCH:
            begin
                q_next     = req;
                idx_next   = '0;
                found_next = 1'b0;
                slot_next  = '0;
                ok_next    = 1'b0;
                asg_next   = '0;
            end
            rrts_pkg::OP_WAKE:
            begin
                if ((rd_st == rrts_pkg::ST_SLEEPING) && (q_reg.tick_value >= rd_wake))
                begin
                    wr_en   = 1'b1;
                    w_wake  = 64'd0;
                    w_st    = rrts_pkg::ST_READY;
                    w_left  = rd_slice;
                    wk_next = wk_reg + 32'd1;
                end
                idx_next = idx_reg + idx_t'(1);
            end
            rrts_pkg::OP_CHARGE:
            begin
                ok_next = 1'b1;
                if (rrts_pkg::is_runnable(rd_st))
                begin
                    wr_en  = 1'b1;
                    w_left = dec_left;
                    if (dec_left == '0)
                        resched_next = 1'b1;
                end
            end
            rrts_pkg::OP_SEARCH_INIT:
            begin
                if (resched_reg)
                begin
                    resched_next = 1'b0;
                    cnt_next     = cnt_t'(1);
                    pick_next    = '0;
                    idx_next     = (run_p1 == slots_reg) ? '0 : idx_t'(run_p1);
                end
            end
            rrts_pkg::OP_SEARCH:
            begin
                if (can_run)
                    pick_next = idx_reg;
                else
                begin
                    idx_next = (idx_p1 == slots_reg) ? '0 : idx_t'(idx_p1);
                    cnt_next = cnt_reg + cnt_t'(1);
                end
            end
            rrts_pkg::OP_RELOAD:
            begin
                wr_en  = 1'b1;
                w_left = rd_slice;
            end
            rrts_pkg::OP_SW_OUT:
            begin
                if (rd_st == rrts_pkg::ST_RUNNING)
                begin
                    wr_en = 1'b1;
                    w_st  = rrts_pkg::ST_READY;
                end
            end
            rrts_pkg::OP_SW_IN:
            begin
                wr_en = 1'b1;
                w_st  = rrts_pkg::ST_RUNNING;
                if (rd_left == '0)
                    w_left = rd_slice;
                run_next = pick_reg;
                sw_next  = sw_reg + 32'd1;
            end
            rrts_pkg::OP_ADD_STEP:
            begin
                if (add_hit)
                begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                end
                idx_next = idx_reg + idx_t'(1);
            end
            rrts_pkg::OP_ADD_WRITE:
            begin
                if (found_reg || (slots_reg < cnt_t'(MAX_TASKS)))
                begin
                    if (!found_reg)
                        slots_next = slots_reg + cnt_t'(1);
                    wr_en     = 1'b1;
                    w_st      = rrts_pkg::ST_READY;
                    w_slice   = slice_t'(sl_clamp);
                    w_left    = slice_t'(sl_clamp);
                    w_wake    = 64'd0;
                    w_ent     = q_reg.has_entry;
                    live_next = live_reg + 32'd1;
                    asg_next  = addr;
                    ok_next   = 1'b1;
                end
            end
            rrts_pkg::OP_SINGLE:
            begin
                case (q_reg.cmd)
                    rrts_pkg::CMD_REMOVE:
                    begin
                        if (!tgt_zero && used)
                        begin
                            wr_en   = 1'b1;
                            w_st    = rrts_pkg::ST_UNUSED;
                            w_slice = '0;
                            w_left  = '0;
                            w_wake  = 64'd0;
                            w_ent   = 1'b0;
                            if (live_reg != 32'd0)
                                live_next = live_reg - 32'd1;
                            if (tgt == run_reg)
                            begin
                                run_next     = '0;
                                resched_next = 1'b1;
                            end
                            ok_next = 1'b1;
                        end
                    end
                    rrts_pkg::CMD_YIELD,
                    rrts_pkg::CMD_SLEEP_FOR,
                    rrts_pkg::CMD_SLEEP_UNTIL:
                    begin
                        if (is_yield)
                        begin
                            if (use_cur || used)
                            begin
                                ok_next = 1'b1;
                                if (rrts_pkg::is_runnable(rd_st))
                                begin
                                    wr_en    = 1'b1;
                                    w_left   = '0;
                                    yld_next = yld_reg + 32'd1;
                                    if (tgt == run_reg)
                                        resched_next = 1'b1;
                                end
                            end
                        end
                        else if (!tgt_zero && (use_cur ? rd_ent : used))
                        begin
                            wr_en  = 1'b1;
                            w_st   = rrts_pkg::ST_SLEEPING;
                            w_wake = (q_reg.cmd == rrts_pkg::CMD_SLEEP_FOR) ?
                                     q_reg.tick_value + q_reg.time_amount : q_reg.time_amount;
                            w_left = rd_slice;
                            if (tgt == run_reg)
                                resched_next = 1'b1;
                            ok_next = 1'b1;
                        end
                    end
                    rrts_pkg::CMD_SET_STATE:
                    begin
                        if (used && !(tgt_zero && !rrts_pkg::is_runnable(q_reg.new_state)))
                        begin
                            wr_en = 1'b1;
                            w_st  = ns_eff;
                            if ((tgt == run_reg) && !rrts_pkg::is_runnable(ns_eff))
                                resched_next = 1'b1;
                            ok_next = 1'b1;
                        end
                    end
                    rrts_pkg::CMD_WAKE:
                    begin
                        if (used && (rd_st != rrts_pkg::ST_ZOMBIE))
                        begin
                            wr_en  = 1'b1;
                            w_st   = rrts_pkg::ST_READY;
                            w_wake = 64'd0;
                            if (rd_left == '0)
                                w_left = rd_slice;
                            wk_next = wk_reg + 32'd1;
                            ok_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            rrts_pkg::OP_LOAD:
            begin
                rsp_next.ok                 = ok_reg;
                rsp_next.assigned_id        = 5'(asg_reg);
                rsp_next.current_task       = 5'(run_reg);
                rsp_next.reschedule_pending = resched_reg;
                rsp_next.live_count         = live_reg[5:0];
                rsp_next.switch_total       = sw_reg;
                rsp_next.yield_total        = yld_reg;
                rsp_next.wakeup_total       = wk_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // slot 0 is the idle task, running with a one-tick slice
            for (int i = 0; i < DEPTH; i++)
            begin
                st_reg[i]    <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_UNUSED;
                slice_reg[i] <= (i == 0) ? slice_t'(1) : '0;
                left_reg[i]  <= (i == 0) ? slice_t'(1) : '0;
                wake_reg[i]  <= 64'd0;
            end
            ent_reg      <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            pick_reg     <= '0;
            slot_reg     <= '0;
            found_reg    <= 1'b0;
            run_reg      <= '0;
            slots_reg    <= cnt_t'(1);
            resched_reg  <= 1'b0;
            live_reg     <= 32'd1;
            sw_reg       <= 32'd0;
            yld_reg      <= 32'd0;
            wk_reg       <= 32'd0;
            ok_reg       <= 1'b0;
            asg_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                st_reg[addr]    <= w_st;
                slice_reg[addr] <= w_slice;
                left_reg[addr]  <= w_left;
                wake_reg[addr]  <= w_wake;
                ent_reg[addr]   <= w_ent;
            end
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            pick_reg    <= pick_next;
            slot_reg    <= slot_next;
            found_reg   <= found_next;
            run_reg     <= run_next;
            slots_reg   <= slots_next;
            resched_reg <= resched_next;
            live_reg    <= live_next;
            sw_reg      <= sw_next;
            yld_reg     <= yld_next;
            wk_reg      <= wk_next;
            ok_reg      <= ok_next;
            asg_reg     <= asg_next;
        end
    end

endmodule
